>>> rtl/dppm_pkg.sv
package dppm_pkg;

	localparam int WINDOW_PAGES_DEF = 2048;
	localparam int POOL_DEPTH_DEF   = 1024;

	localparam logic [31:0] WIN_BASE  = 32'h0800_0000;
	localparam logic [7:0]  ST_MASK   = 8'hf7;
	localparam logic [7:0]  ST_MATCH  = 8'h27;
	localparam int          ST_PERM_BIT = 3;

	localparam logic [10:0] ROM_PAGES_RST  = 11'd0;
	localparam logic [9:0]  POOL_PAGES_RST = 10'd383;

	// register select, taken from paddr[2]
	localparam logic REG_ROM_PAGES  = 1'b0;
	localparam logic REG_POOL_PAGES = 1'b1;

	typedef enum logic [2:0] {
		OUT_PASS       = 3'd0,
		OUT_ALL_LOCKED = 3'd1,
		OUT_LOCKED     = 3'd2,
		OUT_LOAD       = 3'd3,
		OUT_ZERO       = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [7:0]  fault_status;
		logic [31:0] fault_address;
	} fault_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [10:0] window_page;
		logic [9:0]  buffer_index;
		logic        evict_valid;
		logic [10:0] evicted_page;
		logic        writable;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_WCHK,
		S_SEARCH,
		S_OREAD,
		S_OCHK,
		S_MAP
	} ctrl_state_t;

	typedef struct packed {
		logic     load;
		logic     clear_step;
		logic     lock_hit;
		logic     search_init;
		logic     search_step;
		logic     owner_update;
		logic     map_write;
		logic     emit;
		outcome_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic in_window;
		logic perm;
		logic mapped;
		logic pos_lt_rom;
		logic pool_empty;
		logic found;
		logic exhausted;
		logic clear_done;
	} dp_sts_t;

endpackage

>>> rtl/demand_page_pool_manager_unit.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+----------------------------------
// fault    | start, busy, fault                      | taken when start && !busy
// result   | done, result                            | one-cycle strobe, no back-pressure
// config   | psel, penable, pwrite, paddr, pwdata,   | APB write on access phase,
//          | prdata, pready                          | pready tied high
//
// A fault outside the window or rejected by status gets its result from the decode state; a
// read past the ROM, a lock in place or an empty pool from the write check; a claim from the
// map state after the search, owner read and owner check; and a scan that finds every buffer
// locked from the search state. The scan reads one lock flag a cycle from the lock RAM.
// After reset a clearing pass over max(WINDOW_PAGES, POOL_DEPTH) entries (2048 by default)
// runs with busy high. One transaction is in flight at a time; the receiver cannot stall.
module demand_page_pool_manager_unit import dppm_pkg::*; #(
	parameter int WINDOW_PAGES = WINDOW_PAGES_DEF,
	parameter int POOL_DEPTH   = POOL_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  fault_t      fault,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [10:0] rom_pages;
	logic [9:0]  pool_pages;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	dppm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.rom_pages  (rom_pages),
		.pool_pages (pool_pages)
	);

	dppm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	dppm_dp #(
		.WINDOW_PAGES (WINDOW_PAGES),
		.POOL_DEPTH   (POOL_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.fault      (fault),
		.rom_pages  (rom_pages),
		.pool_pages (pool_pages),
		.cmd        (cmd),
		.sts        (sts),
		.done       (done),
		.result     (result)
	);

endmodule

>>> rtl/dppm_regs.sv
module dppm_regs import dppm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [10:0] rom_pages,
	output logic [9:0]  pool_pages
);

	logic [10:0] rom_pages_q;
	logic [9:0]  pool_pages_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_pages_q  <= ROM_PAGES_RST;
			pool_pages_q <= POOL_PAGES_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ROM_PAGES:  rom_pages_q  <= pwdata[10:0];
				REG_POOL_PAGES: pool_pages_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_ROM_PAGES:  prdata = {21'd0, rom_pages_q};
			REG_POOL_PAGES: prdata = {22'd0, pool_pages_q};
			default: ;
		endcase
	end

	assign rom_pages  = rom_pages_q;
	assign pool_pages = pool_pages_q;

endmodule

>>> rtl/dppm_ctrl.sv
module dppm_ctrl import dppm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = OUT_PASS;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.in_window) begin
					cmd.emit = 1'b1;
					cmd.kind = OUT_PASS;
					state_d  = S_IDLE;
				end else begin
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				priority if (sts.perm && sts.mapped) begin
					cmd.lock_hit = 1'b1;
					cmd.emit     = 1'b1;
					cmd.kind     = OUT_LOCKED;
					state_d      = S_IDLE;
				end else if (!sts.perm && !sts.pos_lt_rom) begin
					cmd.emit = 1'b1;
					cmd.kind = OUT_PASS;
					state_d  = S_IDLE;
				end else if (sts.pool_empty) begin
					cmd.emit = 1'b1;
					cmd.kind = OUT_ALL_LOCKED;
					state_d  = S_IDLE;
				end else begin
					cmd.search_init = 1'b1;
					state_d         = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				priority if (sts.found) begin
					state_d = S_OREAD;
				end else if (sts.exhausted) begin
					cmd.emit = 1'b1;
					cmd.kind = OUT_ALL_LOCKED;
					state_d  = S_IDLE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_OREAD: state_d = S_OCHK;
			S_OCHK: begin
				cmd.owner_update = 1'b1;
				state_d          = S_MAP;
			end
			S_MAP: begin
				cmd.map_write = 1'b1;
				cmd.emit      = 1'b1;
				cmd.kind      = sts.pos_lt_rom ? OUT_LOAD : OUT_ZERO;
				state_d       = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

>>> rtl/dppm_dp.sv
module dppm_dp import dppm_pkg::*; #(
	parameter int WINDOW_PAGES = WINDOW_PAGES_DEF,
	parameter int POOL_DEPTH   = POOL_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fault_t      fault,
	input  logic [10:0] rom_pages,
	input  logic [9:0]  pool_pages,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        done,
	output result_t     result
);

	localparam int WPW     = $clog2(WINDOW_PAGES);
	localparam int PIW     = $clog2(POOL_DEPTH);
	localparam int NW      = $clog2(POOL_DEPTH + 1);
	localparam int NW1     = NW + 1;
	localparam int CMW     = (NW > 10) ? NW : 10;
	localparam int RW      = (WPW > 11) ? WPW : 11;
	localparam int BW      = $clog2(POOL_DEPTH + 1);
	localparam int OWW     = $clog2(WINDOW_PAGES + 1);
	localparam int CLR_LEN = (WINDOW_PAGES > POOL_DEPTH) ? WINDOW_PAGES : POOL_DEPTH;
	localparam int CLW     = $clog2(CLR_LEN);

	// window table: buffer index plus one; lock flags and owners per buffer
	logic [BW-1:0]  win_mem [WINDOW_PAGES];
	logic           lock_mem [POOL_DEPTH];
	logic [OWW-1:0] own_mem [POOL_DEPTH];

	fault_t         fault_q;
	logic [BW-1:0]  win_rd_q;
	logic [OWW-1:0] own_rd_q;
	logic [PIW-1:0] cursor_q;
	logic [PIW-1:0] ia_q;
	logic [NW-1:0]  ic_q;
	logic [PIW-1:0] sel_q;
	logic           evict_q;
	logic [WPW-1:0] ev_q;
	logic [CLW-1:0] clr_q;
	logic           done_q;
	result_t        result_q;

	logic           lock_rd_s1;
	logic [PIW-1:0] i_s1;
	logic           v_s1;
	logic           last_s1;

	logic [31:0]    off;
	logic [WPW-1:0] pos;
	logic           perm;
	logic [NW-1:0]  n;
	logic           issue;
	logic [PIW-1:0] ia_next;
	logic [PIW-1:0] cur_next;
	logic [PIW-1:0] hit_buf;
	logic           evict_now;
	logic [WPW-1:0] ev_now;
	logic           clr_win;
	logic           clr_pool;
	result_t        res_d;

	function automatic logic [PIW-1:0] wrap_next(input logic [PIW-1:0] i, input logic [NW-1:0] cnt);
		logic [NW1-1:0] inc;
		inc = NW1'(i) + NW1'(1);
		return (inc >= NW1'(cnt)) ? '0 : PIW'(inc);
	endfunction

	assign off  = fault_q.fault_address - WIN_BASE;
	assign pos  = off[12 +: WPW];
	assign perm = fault_q.fault_status[ST_PERM_BIT];
	assign n    = (CMW'(pool_pages) > CMW'(POOL_DEPTH)) ? NW'(POOL_DEPTH) : NW'(pool_pages);

	assign issue     = cmd.search_step && (ic_q < n);
	assign ia_next   = wrap_next(ia_q, n);
	assign cur_next  = wrap_next(cursor_q, n);
	assign hit_buf   = PIW'(win_rd_q - BW'(1));
	assign evict_now = (own_rd_q != '0);
	assign ev_now    = WPW'(own_rd_q - OWW'(1));
	assign clr_win   = (32'(clr_q) < 32'(WINDOW_PAGES));
	assign clr_pool  = (32'(clr_q) < 32'(POOL_DEPTH));

	always_comb begin
		sts            = '0;
		sts.in_window  = ((fault_q.fault_status & ST_MASK) == ST_MATCH)
			&& (off[31:12] < 20'(WINDOW_PAGES));
		sts.perm       = perm;
		sts.mapped     = (win_rd_q != '0);
		sts.pos_lt_rom = (RW'(pos) < RW'(rom_pages));
		sts.pool_empty = (n == '0);
		sts.found      = v_s1 && !lock_rd_s1;
		sts.exhausted  = v_s1 && lock_rd_s1 && last_s1;
		sts.clear_done = (clr_q == CLW'(CLR_LEN - 1));
	end

	// memories
	always_ff @(posedge clk) begin
		win_rd_q <= win_mem[pos];
		priority if (cmd.clear_step && clr_win) begin
			win_mem[clr_q[WPW-1:0]] <= '0;
		end else if (cmd.owner_update && evict_now) begin
			win_mem[ev_now] <= '0;
		end else if (cmd.map_write) begin
			win_mem[pos] <= BW'(sel_q) + BW'(1);
		end
	end

	always_ff @(posedge clk) begin
		lock_rd_s1 <= lock_mem[ia_q];
		priority if (cmd.clear_step && clr_pool) begin
			lock_mem[clr_q[PIW-1:0]] <= 1'b0;
		end else if (cmd.lock_hit) begin
			lock_mem[hit_buf] <= 1'b1;
		end else if (cmd.owner_update && perm) begin
			lock_mem[sel_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		own_rd_q <= own_mem[sel_q];
		priority if (cmd.clear_step && clr_pool) begin
			own_mem[clr_q[PIW-1:0]] <= '0;
		end else if (cmd.owner_update) begin
			own_mem[sel_q] <= perm ? '0 : OWW'(pos) + OWW'(1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			cursor_q <= '0;
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + CLW'(1);
			if (cmd.owner_update) cursor_q <= sel_q;
			v_s1   <= issue;
			done_q <= cmd.emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) fault_q <= fault;
		if (cmd.search_init) begin
			ia_q <= cur_next;
			ic_q <= '0;
		end else if (issue) begin
			ia_q <= ia_next;
			ic_q <= ic_q + NW'(1);
		end
		if (issue) begin
			i_s1    <= ia_q;
			last_s1 <= (NW1'(ic_q) + NW1'(1) == NW1'(n));
		end
		if (cmd.search_step && sts.found) sel_q <= i_s1;
		if (cmd.owner_update) begin
			evict_q <= evict_now;
			ev_q    <= ev_now;
		end
		if (cmd.emit) result_q <= res_d;
	end

	always_comb begin
		res_d         = '0;
		res_d.outcome = cmd.kind;
		unique case (cmd.kind)
			OUT_PASS: res_d = '0;
			OUT_ALL_LOCKED: res_d.window_page = 11'(pos);
			OUT_LOCKED: begin
				res_d.window_page  = 11'(pos);
				res_d.buffer_index = 10'(hit_buf);
				res_d.writable     = 1'b1;
			end
			OUT_LOAD, OUT_ZERO: begin
				res_d.window_page  = 11'(pos);
				res_d.buffer_index = 10'(sel_q);
				res_d.evict_valid  = evict_q;
				res_d.evicted_page = evict_q ? 11'(ev_q) : 11'd0;
				res_d.writable     = perm;
			end
			default: res_d = '0;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import dppm_pkg::*;

	localparam logic [7:0]  TRANSLATION_FAULT = ST_MATCH;
	localparam logic [7:0]  PERMISSION_FAULT  = ST_MATCH | (8'd1 << ST_PERM_BIT);
	localparam logic [31:0] WIN_SPAN          = WINDOW_PAGES_DEF * 4096;
	localparam logic [2:0]  ROM_PAGES_ADDR    = {REG_ROM_PAGES, 2'b00};
	localparam logic [2:0]  POOL_PAGES_ADDR   = {REG_POOL_PAGES, 2'b00};
	localparam int          RANDOM_PHASES     = 10;
	localparam int          PHASE_FAULTS      = 49;
	localparam longint      CYCLE_LIMIT       = 3_000_000;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	fault_t      fault   = '0;
	logic        done;
	result_t     result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the block's tables
	bit [10:0]   page_buf [WINDOW_PAGES_DEF];	// buffer index plus one, 0 when not loaded
	bit [11:0]   buf_owner [POOL_DEPTH_DEF];	// owner page plus one, 0 when free
	bit          buf_locked [POOL_DEPTH_DEF];
	int unsigned rr_cursor;
	int unsigned rom_pages_cfg  = 32'(ROM_PAGES_RST);
	int unsigned pool_pages_cfg = 32'(POOL_PAGES_RST);

	fault_t      fault_backlog [$];
	result_t     due_results [$];
	result_t     want;
	int unsigned burst_left, gap_left, faults_taken, mismatches, evictions;
	int unsigned outcome_seen [5];
	longint unsigned cycles;

	demand_page_pool_manager_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.fault   (fault),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t resolve_fault(input fault_t f);
		result_t     r;
		logic [31:0] off;
		int unsigned pos, n, idx, k, prev, ev;
		bit          perm, found;
		r = '0;
		r.outcome = OUT_PASS;
		off = f.fault_address - WIN_BASE;
		if ((f.fault_status & ST_MASK) != ST_MATCH || off >= WIN_SPAN)
			return r;
		pos = off >> 12;
		perm = f.fault_status[ST_PERM_BIT];
		if (perm && page_buf[pos] != 0) begin
			idx = page_buf[pos] - 1;
			buf_locked[idx] = 1'b1;
			r.outcome = OUT_LOCKED;
			r.window_page = pos[10:0];
			r.buffer_index = idx[9:0];
			r.writable = 1'b1;
			return r;
		end
		// nothing to load for a read past the ROM
		if (!perm && pos >= rom_pages_cfg)
			return r;
		n = (pool_pages_cfg > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : pool_pages_cfg;
		idx = rr_cursor;
		found = 1'b0;
		for (k = 0; k < n && !found; k++) begin
			idx = (idx + 1 >= n) ? 0 : idx + 1;
			found = !buf_locked[idx];
		end
		r.window_page = pos[10:0];
		if (!found) begin
			r.outcome = OUT_ALL_LOCKED;
			return r;
		end
		prev = 32'(buf_owner[idx]);
		buf_owner[idx] = perm ? 12'd0 : 12'(pos + 1);
		if (perm)
			buf_locked[idx] = 1'b1;
		rr_cursor = idx;
		r.outcome = (pos < rom_pages_cfg) ? OUT_LOAD : OUT_ZERO;
		r.buffer_index = idx[9:0];
		if (prev != 0) begin
			ev = (prev - 1) % WINDOW_PAGES_DEF;
			page_buf[ev] = '0;
			r.evict_valid = 1'b1;
			r.evicted_page = ev[10:0];
		end
		page_buf[pos] = 11'(idx + 1);
		r.writable = perm;
		return r;
	endfunction

	task automatic queue_fault(input logic [7:0] status, input logic [31:0] addr);
		fault_backlog.push_back({status, addr});
	endtask

	// write a register, then read it back
	task automatic program_reg(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] held;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		if (addr == ROM_PAGES_ADDR)
			rom_pages_cfg = value & 32'h7ff;
		else
			pool_pages_cfg = value & 32'h3ff;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		held = (addr == ROM_PAGES_ADDR) ? rom_pages_cfg : pool_pages_cfg;
		if (prdata !== held) begin
			$display("%0t: register at %0d expected %0d, got %0d", $time, addr, held, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		while (fault_backlog.size() != 0 || due_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic flag_field(input string name, input logic [31:0] want_val,
			input logic [31:0] got_val);
		$display("%0t: %s expected %0d, got %0d", $time, name, want_val, got_val);
		mismatches++;
	endtask

	// driver: one fault per transaction, sent in bursts with gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				due_results.push_back(resolve_fault(fault));
				void'(fault_backlog.pop_front());
				faults_taken++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			// hold a transaction the block has not yet taken
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (fault_backlog.size() > 0) begin
					start <= 1'b1;
					fault <= fault_backlog[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$display("%0t: expected no result, got %p", $time, result);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (result.outcome !== want.outcome)
					flag_field("outcome", 32'(want.outcome), 32'(result.outcome));
				if (result.window_page !== want.window_page)
					flag_field("window_page", 32'(want.window_page),
						32'(result.window_page));
				if (result.buffer_index !== want.buffer_index)
					flag_field("buffer_index", 32'(want.buffer_index),
						32'(result.buffer_index));
				if (result.evict_valid !== want.evict_valid)
					flag_field("evict_valid", 32'(want.evict_valid),
						32'(result.evict_valid));
				if (result.evicted_page !== want.evicted_page)
					flag_field("evicted_page", 32'(want.evicted_page),
						32'(result.evicted_page));
				if (result.writable !== want.writable)
					flag_field("writable", 32'(want.writable), 32'(result.writable));
			end
			if (result.outcome <= OUT_ZERO)
				outcome_seen[result.outcome]++;
			if (result.evict_valid === 1'b1)
				evictions++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run stalled after %0d cycles", $time, cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int unsigned ph, rom, pool, perm_pct, span, base, counted, roll, pos;
		logic [31:0] addr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// ride out the clearing pass
		drain();

		// reset settings: no ROM, pool of 383
		queue_fault(8'h00, WIN_BASE);
		queue_fault(8'hff, 32'hffff_ffff);
		queue_fault(TRANSLATION_FAULT, 32'h0000_0000);
		queue_fault(PERMISSION_FAULT, WIN_BASE - 1);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + WIN_SPAN);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + 32'h123);
		queue_fault(PERMISSION_FAULT, WIN_BASE);
		queue_fault(PERMISSION_FAULT, WIN_BASE + WIN_SPAN - 1);
		queue_fault(PERMISSION_FAULT, WIN_BASE + 32'h10);
		queue_fault(8'h37, WIN_BASE + 32'h2000);
		drain();

		// empty pool
		program_reg(ROM_PAGES_ADDR, 1024);
		program_reg(POOL_PAGES_ADDR, 0);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + 32'h5000);
		queue_fault(PERMISSION_FAULT, WIN_BASE + WIN_SPAN - 32'h800);
		drain();

		// single buffer, cursor beyond the pool
		program_reg(POOL_PAGES_ADDR, 1);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + 32'h5000);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + 32'h6abc);
		queue_fault(PERMISSION_FAULT, WIN_BASE + 32'h6000);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + 32'h7000);
		queue_fault(PERMISSION_FAULT, WIN_BASE + (32'd1500 << 12));
		drain();

		// largest pool, around the end of the ROM
		program_reg(POOL_PAGES_ADDR, 1023);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + (32'd1023 << 12) + 32'hfff);
		queue_fault(TRANSLATION_FAULT, WIN_BASE + (32'd1024 << 12));
		queue_fault(PERMISSION_FAULT, WIN_BASE + (32'd1024 << 12) + 32'h44);
		queue_fault(PERMISSION_FAULT, WIN_BASE + (32'd1023 << 12));
		queue_fault(TRANSLATION_FAULT, WIN_BASE + (32'd1023 << 12) + 32'h8);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: pool = 4;
				1: pool = 200;
				2: pool = 12;
				3: pool = 1023;
				4: pool = 28;
				5: pool = 383;
				6: pool = 60;
				7: pool = 9;
				8: pool = 150;
				default: pool = 100;
			endcase
			rom = (ph == 0) ? 1024 : (ph == 1) ? 0 : $urandom_range(0, 1024);
			perm_pct = $urandom_range(4, 25);
			span = (2 * pool + 4 > 300) ? 300 : 2 * pool + 4;
			// even phases straddle the end of the ROM, odd ones land anywhere
			base = (ph % 2 == 0) ? (rom + WINDOW_PAGES_DEF - span / 2) % WINDOW_PAGES_DEF
				: $urandom_range(0, WINDOW_PAGES_DEF - 1);
			drain();
			program_reg(ROM_PAGES_ADDR, rom);
			program_reg(POOL_PAGES_ADDR, pool);
			counted = 0;
			while (counted < PHASE_FAULTS) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					queue_fault(8'($urandom_range(0, 255)), $urandom());
				end else if (roll < 13) begin
					addr = $urandom_range(0, 1) ? $urandom_range(0, WIN_BASE - 1)
						: $urandom_range(WIN_BASE + WIN_SPAN, 32'hffff_ffff);
					queue_fault($urandom_range(0, 1) ? PERMISSION_FAULT : TRANSLATION_FAULT,
						addr);
				end else begin
					pos = (base + $urandom_range(0, span - 1)) % WINDOW_PAGES_DEF;
					addr = WIN_BASE + (pos << 12) + $urandom_range(0, 4095);
					queue_fault(($urandom_range(0, 99) < perm_pct) ? PERMISSION_FAULT
						: TRANSLATION_FAULT, addr);
					counted++;
				end
			end
		end

		drain();
		repeat (1100) @(posedge clk);
		$display("%0d faults over %0d pool settings; pass %0d, all locked %0d, lock in place %0d",
			faults_taken, RANDOM_PHASES + 4, outcome_seen[OUT_PASS],
			outcome_seen[OUT_ALL_LOCKED], outcome_seen[OUT_LOCKED]);
		$display("ROM loads %0d, zero fills %0d, evictions %0d",
			outcome_seen[OUT_LOAD], outcome_seen[OUT_ZERO], evictions);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
rtl/dppm_pkg.sv
rtl/dppm_regs.sv
rtl/dppm_ctrl.sv
rtl/dppm_dp.sv
rtl/demand_page_pool_manager_unit.sv
test/tb.sv
